// ===== hdl/rshe_pkg.sv =====
// package: fixed-point constants, types and rounding helpers for the harmonic core
`timescale 1ns / 1ps
`default_nettype none
package rshe_pkg;
	localparam int FracBits = 14;
	localparam int CoefBits = 20;
	localparam int WW = 32;
	localparam int CFG_W = 20;
	localparam int NORM_W = 35;
	localparam int TDATA_IN_W = 56;
	localparam int TDATA_OUT_W = 24;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_LM   = 2'd2;

	localparam logic signed [WW-1:0] ONE = WW'(1) <<< FracBits;

	// unsigned q4.20 coefficients
	localparam logic [23:0] K_R3    = 24'd1816187;
	localparam logic [23:0] K_R3H   = 24'd908093;
	localparam logic [23:0] K_R5_8  = 24'd828972;
	localparam logic [23:0] K_R15   = 24'd4061117;
	localparam logic [23:0] K_R3_8  = 24'd642119;
	localparam logic [23:0] K_R15_4 = 24'd2030559;
	localparam logic [23:0] K_R35H  = 24'd3101730;
	localparam logic [23:0] K_R175H = 24'd2193254;
	localparam logic [23:0] K_R5_6  = 24'd390781;
	localparam logic [23:0] K_R5_12 = 24'd195391;
	localparam logic [23:0] K_R35_8 = 24'd775432;
	localparam logic [23:0] K_C55   = 24'd735640;
	localparam logic [23:0] K_C54   = 24'd9305189;
	localparam logic [23:0] K_C53   = 24'd548314;
	localparam logic [23:0] K_R105H = 24'd5372353;
	localparam logic [23:0] K_R15_8 = 24'd507640;
	localparam logic [23:0] K_R105Q = 24'd2686177;
	localparam logic [23:0] K_C5P4  = 24'd2326297;

	typedef struct packed {
		logic [1:0]        status;
		logic [5:0]        idx;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} item_t;

	// round half away from zero, shift by fraction bits
	function automatic logic signed [WW-1:0] rnd_frac(input logic signed [2*WW-1:0] v);
		logic [2*WW-1:0] mag;
		mag = v[2*WW-1] ? -v : v;
		mag = (mag + (2*WW)'(1 << (FracBits - 1))) >> FracBits;
		rnd_frac = v[2*WW-1] ? -WW'(mag) : WW'(mag);
	endfunction

	function automatic logic signed [WW-1:0] rnd_coef(input logic signed [2*WW-1:0] v);
		logic [2*WW-1:0] mag;
		mag = v[2*WW-1] ? -v : v;
		mag = (mag + (2*WW)'(1 << (CoefBits - 1))) >> CoefBits;
		rnd_coef = v[2*WW-1] ? -WW'(mag) : WW'(mag);
	endfunction

	function automatic logic signed [WW-1:0] rnd_sh(input logic signed [WW-1:0] v,
			input int unsigned sh);
		logic [WW-1:0] mag;
		mag = v[WW-1] ? -v : v;
		mag = (mag + (WW'(1) << (sh - 1))) >> sh;
		rnd_sh = v[WW-1] ? -mag : mag;
	endfunction

	function automatic logic signed [WW-1:0] fmul(input logic signed [WW-1:0] a,
			input logic signed [WW-1:0] b);
		fmul = rnd_frac((2*WW)'(a) * (2*WW)'(b));
	endfunction

	function automatic logic signed [WW-1:0] kmul(input logic signed [WW-1:0] a,
			input logic [23:0] k);
		kmul = rnd_coef((2*WW)'(a) * (2*WW)'(k));
	endfunction
endpackage
`default_nettype wire

// ===== hdl/rshe_check.sv =====
// front stage: norm check, table index and status
`timescale 1ns / 1ps
`default_nettype none
module rshe_check (
	input  wire logic [2:0]                     degree,
	input  wire logic signed [3:0]              order,
	input  wire logic signed [15:0]             dir_x,
	input  wire logic signed [15:0]             dir_y,
	input  wire logic signed [15:0]             dir_z,
	input  wire logic [rshe_pkg::CFG_W-1:0]     tol,
	output rshe_pkg::item_t                     item
);
	logic signed [rshe_pkg::NORM_W-1:0] sum, dev;
	logic signed [31:0] px, py, pz;
	logic [3:0] am;
	always_comb begin
		px = dir_x * dir_x;
		py = dir_y * dir_y;
		pz = dir_z * dir_z;
		sum = rshe_pkg::NORM_W'(px) + rshe_pkg::NORM_W'(py) + rshe_pkg::NORM_W'(pz)
			- (rshe_pkg::NORM_W'(1) <<< (2 * rshe_pkg::FracBits));
		dev = sum[rshe_pkg::NORM_W-1] ? -sum : sum;
		am = order[3] ? 4'(-{order[3], order}) : 4'(order);
		item.x = dir_x;
		item.y = dir_y;
		item.z = dir_z;
		item.idx = 6'(degree) * 6'(degree) + 6'(degree)
			+ 6'(signed'({{2{order[3]}}, order}));
		if (dev > rshe_pkg::NORM_W'(tol))
			item.status = rshe_pkg::ST_NORM;
		else if (degree > 3'd5 || {1'b0, am} > {2'b0, degree})
			item.status = rshe_pkg::ST_LM;
		else
			item.status = rshe_pkg::ST_OK;
	end
endmodule
`default_nettype wire

// ===== hdl/rshe_eval.sv =====
// pipelined polynomial evaluation: products, higher powers, table term, coefficient
`timescale 1ns / 1ps
`default_nettype none
module rshe_eval (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  rshe_pkg::item_t                  in_item,
	output logic                             out_valid,
	output logic signed [15:0]               out_value,
	output logic [1:0]                       out_status
);
	localparam int W = rshe_pkg::WW;
	typedef logic signed [W-1:0] w_t;

	// stage 1: quadratics
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	rshe_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5;
	w_t xx_s1, yy_s1, zz_s1, xy_s1, zx_s1, zy_s1;
	// stage 2: quartics
	w_t xx_s2, yy_s2, zz_s2, xy_s2, zx_s2, zy_s2, z4_s2, x4_s2, y4_s2, x2y2_s2;
	// stage 3/4: term pair and product
	w_t a_s3, b_s3, c_s3;
	logic [1:0] op_s3, op_s4;
	w_t t_s4, c_s4;
	logic [23:0] k_s3, k_s4, k_s5;
	logic [1:0] fin_s3, fin_s4, fin_s5;
	w_t t_s5;

	// term selection for the table entry
	w_t a_c, b_c, c_c, dxy, p4, q5, z3m_a, zz3, y3, x3;
	logic [1:0] op_c, fin_c;
	logic [23:0] k_c;
	w_t x, y, z;
	w_t f;

	localparam logic [1:0] F_RAW = 2'd0;
	localparam logic [1:0] F_K   = 2'd1;
	localparam logic [1:0] F_H1  = 2'd2;
	localparam logic [1:0] F_H3  = 2'd3;

	localparam logic [1:0] OP_A   = 2'd0;
	localparam logic [1:0] OP_AB  = 2'd1;
	localparam logic [1:0] OP_ABC = 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= in_item;
			xx_s1 <= rshe_pkg::fmul(W'(in_item.x), W'(in_item.x));
			yy_s1 <= rshe_pkg::fmul(W'(in_item.y), W'(in_item.y));
			zz_s1 <= rshe_pkg::fmul(W'(in_item.z), W'(in_item.z));
			xy_s1 <= rshe_pkg::fmul(W'(in_item.x), W'(in_item.y));
			zx_s1 <= rshe_pkg::fmul(W'(in_item.z), W'(in_item.x));
			zy_s1 <= rshe_pkg::fmul(W'(in_item.z), W'(in_item.y));

			it_s2 <= it_s1;
			xx_s2 <= xx_s1; yy_s2 <= yy_s1; zz_s2 <= zz_s1;
			xy_s2 <= xy_s1; zx_s2 <= zx_s1; zy_s2 <= zy_s1;
			z4_s2 <= rshe_pkg::fmul(zz_s1, zz_s1);
			x4_s2 <= rshe_pkg::fmul(xx_s1, xx_s1);
			y4_s2 <= rshe_pkg::fmul(yy_s1, yy_s1);
			x2y2_s2 <= rshe_pkg::fmul(xy_s1, xy_s1);

			it_s3 <= it_s2;
			a_s3 <= a_c; b_s3 <= b_c; c_s3 <= c_c; op_s3 <= op_c;
			k_s3 <= k_c; fin_s3 <= fin_c;

			it_s4 <= it_s3;
			k_s4 <= k_s3; fin_s4 <= fin_s3; c_s4 <= c_s3; op_s4 <= op_s3;
			case (op_s3)
				OP_A:    t_s4 <= a_s3;
				default: t_s4 <= rshe_pkg::fmul(a_s3, b_s3);
			endcase

			it_s5 <= it_s4;
			k_s5 <= k_s4; fin_s5 <= fin_s4;
			t_s5 <= (op_s4 == OP_ABC) ? rshe_pkg::fmul(t_s4, c_s4) : t_s4;
		end
	end

	always_comb begin
		x = W'(it_s2.x); y = W'(it_s2.y); z = W'(it_s2.z);
		dxy = xx_s2 - yy_s2;
		p4 = x4_s2 - 6 * x2y2_s2 + y4_s2;
		q5 = 21 * z4_s2 - 14 * zz_s2 + rshe_pkg::ONE;
		zz3 = 3 * zz_s2 - rshe_pkg::ONE;
		z3m_a = z;
		y3 = 3 * xx_s2 - yy_s2;
		x3 = xx_s2 - 3 * yy_s2;
		a_c = '0; b_c = '0; c_c = '0; op_c = OP_A; fin_c = F_RAW; k_c = '0;
		case (it_s2.idx)
			6'd0:  a_c = rshe_pkg::ONE;
			6'd1:  a_c = y;
			6'd2:  a_c = z;
			6'd3:  a_c = x;
			6'd4:  begin a_c = xy_s2; fin_c = F_K; k_c = rshe_pkg::K_R3; end
			6'd5:  begin a_c = zy_s2; fin_c = F_K; k_c = rshe_pkg::K_R3; end
			6'd6:  begin a_c = zz3; fin_c = F_H1; end
			6'd7:  begin a_c = zx_s2; fin_c = F_K; k_c = rshe_pkg::K_R3; end
			6'd8:  begin a_c = dxy; fin_c = F_K; k_c = rshe_pkg::K_R3H; end
			6'd9:  begin a_c = y; b_c = y3; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R5_8; end
			6'd10: begin a_c = xy_s2; b_c = z; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R15; end
			6'd11: begin a_c = y; b_c = 5 * zz_s2 - rshe_pkg::ONE; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R3_8; end
			6'd12: begin a_c = z; b_c = 5 * zz_s2 - 3 * rshe_pkg::ONE; op_c = OP_AB;
				fin_c = F_H1; end
			6'd13: begin a_c = x; b_c = 5 * zz_s2 - rshe_pkg::ONE; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R3_8; end
			6'd14: begin a_c = z; b_c = dxy; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R15_4; end
			6'd15: begin a_c = x; b_c = x3; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R5_8; end
			6'd16: begin a_c = xy_s2; b_c = dxy; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R35H; end
			6'd17: begin a_c = zy_s2; b_c = y3; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R175H; end
			6'd18: begin a_c = 21 * zz_s2 - 3 * rshe_pkg::ONE; b_c = xy_s2; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R5_6; end
			6'd19: begin a_c = zy_s2; b_c = 7 * zz_s2 - 3 * rshe_pkg::ONE; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R5_8; end
			6'd20: begin a_c = 35 * z4_s2 - 30 * zz_s2 + 3 * rshe_pkg::ONE; fin_c = F_H3; end
			6'd21: begin a_c = zx_s2; b_c = 7 * zz_s2 - 3 * rshe_pkg::ONE; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R5_8; end
			6'd22: begin a_c = 21 * zz_s2 - 3 * rshe_pkg::ONE; b_c = dxy; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_R5_12; end
			6'd23: begin a_c = zx_s2; b_c = x3; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R175H; end
			6'd24: begin a_c = p4; fin_c = F_K; k_c = rshe_pkg::K_R35_8; end
			6'd25: begin a_c = y; b_c = 5 * x4_s2 - 10 * x2y2_s2 + y4_s2; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_C55; end
			6'd26: begin a_c = z; b_c = xy_s2; c_c = dxy; op_c = OP_ABC; fin_c = F_K;
				k_c = rshe_pkg::K_C54; end
			6'd27: begin a_c = y; b_c = y3; c_c = 9 * zz_s2 - rshe_pkg::ONE; op_c = OP_ABC;
				fin_c = F_K; k_c = rshe_pkg::K_C53; end
			6'd28: begin a_c = z3m_a; b_c = zz3; c_c = xy_s2; op_c = OP_ABC; fin_c = F_K;
				k_c = rshe_pkg::K_R105H; end
			6'd29: begin a_c = y; b_c = q5; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R15_8; end
			6'd30: begin a_c = z; b_c = 63 * z4_s2 - 70 * zz_s2 + 15 * rshe_pkg::ONE;
				op_c = OP_AB; fin_c = F_H3; end
			6'd31: begin a_c = x; b_c = q5; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_R15_8; end
			6'd32: begin a_c = z3m_a; b_c = zz3; c_c = dxy; op_c = OP_ABC; fin_c = F_K;
				k_c = rshe_pkg::K_R105Q; end
			6'd33: begin a_c = x; b_c = x3; c_c = 9 * zz_s2 - rshe_pkg::ONE; op_c = OP_ABC;
				fin_c = F_K; k_c = rshe_pkg::K_C53; end
			6'd34: begin a_c = z; b_c = p4; op_c = OP_AB; fin_c = F_K;
				k_c = rshe_pkg::K_C5P4; end
			6'd35: begin a_c = x; b_c = x4_s2 - 10 * x2y2_s2 + 5 * y4_s2; op_c = OP_AB;
				fin_c = F_K; k_c = rshe_pkg::K_C55; end
			default: a_c = '0;
		endcase
	end

	// stage 6: coefficient, rounding shift, saturation
	always_comb begin
		case (fin_s5)
			F_K:     f = rshe_pkg::kmul(t_s5, k_s5);
			F_H1:    f = rshe_pkg::rnd_sh(t_s5, 1);
			F_H3:    f = rshe_pkg::rnd_sh(t_s5, 3);
			default: f = t_s5;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_status <= it_s5.status;
			if (it_s5.status != rshe_pkg::ST_OK)
				out_value <= '0;
			else if (f > W'(32767))
				out_value <= 16'sh7fff;
			else if (f < -W'(32768))
				out_value <= -16'sh8000;
			else
				out_value <= 16'(f);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/real_spherical_harmonic_eval_core.sv =====
// top level: stream ports, tolerance register, check and evaluation pipeline
`timescale 1ns / 1ps
`default_nettype none
// Evaluates real semi-normalized spherical harmonics up to degree five in Q1.14.
// Fully pipelined: one request per cycle while the output is not stalled. A result passes
// through six register stages (squares, fourth powers, term selection, first product,
// third factor, coefficient multiply with saturation). Backpressure stalls the whole
// pipeline in place while the output holds. Write norm_tolerance only while idle.
module real_spherical_harmonic_eval_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// degree[2:0], order[6:3], dir_x[22:7], dir_y[38:23], dir_z[54:39], zero fill
	input  wire logic [rshe_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// harmonic_value[15:0], status[17:16], zero fill
	output logic [rshe_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rshe_pkg::CFG_W-1:0]          cfg_data
);
	logic [rshe_pkg::CFG_W-1:0] tol_q;
	rshe_pkg::item_t item;
	logic en;
	logic signed [15:0] value;
	logic [1:0] status;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= rshe_pkg::CFG_W'(65536);
		else if (cfg_valid)
			tol_q <= cfg_data;
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	rshe_check u_check (
		.degree(s_axis_tdata[2:0]),
		.order(s_axis_tdata[6:3]),
		.dir_x(s_axis_tdata[22:7]),
		.dir_y(s_axis_tdata[38:23]),
		.dir_z(s_axis_tdata[54:39]),
		.tol(tol_q),
		.item(item)
	);

	rshe_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_axis_tvalid),
		.in_item(item),
		.out_valid(m_axis_tvalid),
		.out_value(value),
		.out_status(status)
	);

	assign m_axis_tdata = {6'b0, status, value};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[17:16] != rshe_pkg::ST_OK |-> m_axis_tdata[15:0] == 16'd0)
		else $error("flagged result not zero");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
		else $error("bad status code");
endmodule
`default_nettype wire
